@@ hdl/mmt_pkg.sv @@
// ----------------------------------------------------------------------------
// mmt_pkg
// Types, NFA constants and helper functions of the maximal munch tokenizer.
// ----------------------------------------------------------------------------
package mmt_pkg;

	localparam int CNT_W       = 16;
	localparam int KIND_W      = 4;
	localparam int NFA_STATES  = 51;
	localparam int CHAIN_LAST  = 45;
	localparam int NUM_KINDS   = 15;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CNT_W-1:0]  CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0]  CNT_MAX = '1;
	localparam logic [KIND_W-1:0] KIND_LET = 4'd0;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_UNDER   = 8'h5F;

	// NFA state numbers (1-based, bit s-1 of the set)
	localparam int ST_NUM_START   = 46;
	localparam int ST_NUM_ACCEPT  = 47;
	localparam int ST_OPID_START  = 48;
	localparam int ST_OPID_ACCEPT = 49;
	localparam int ST_ID_START    = 50;
	localparam int ST_ID_ACCEPT   = 51;

	// Character that moves keyword/punctuation chain state s to s+1 (index s-1)
	localparam logic [7:0] CHAIN_CHAR [CHAIN_LAST] = '{
		"l", "e", "t", 8'h00,
		"=", 8'h00,
		"o", "p", "e", "r", "a", "t", "o", "r", 8'h00,
		"r", "e", "t", "u", "r", "n", 8'h00,
		"(", 8'h00,
		")", 8'h00,
		";", 8'h00,
		"i", "f", 8'h00,
		"t", "h", "e", "n", 8'h00,
		"e", "l", "s", "e", 8'h00,
		"[", 8'h00,
		"]", 8'h00
	};

	localparam int KIND_START [NUM_KINDS] = '{
		1, 5, 7, 16, 23, 25, 27, 29, 32, 37, 42, 44, 46, 48, 50
	};
	localparam int KIND_ACCEPT [NUM_KINDS] = '{
		4, 6, 15, 22, 24, 26, 28, 31, 36, 41, 43, 45, 47, 49, 51
	};

	typedef logic [NFA_STATES-1:0] nfa_set_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		logic              is_error;
		logic [KIND_W-1:0] token_kind;
		logic [CNT_W-1:0]  start_line;
		logic [CNT_W-1:0]  start_column;
		logic [CNT_W-1:0]  token_length;
		logic              last_of_run;
	} result_t;

	// Results caused by one input item: an optional token, then an optional error
	typedef struct packed {
		logic              tok_v;
		logic              err_v;
		logic [KIND_W-1:0] kind;
		logic [CNT_W-1:0]  tok_line;
		logic [CNT_W-1:0]  tok_col;
		logic [CNT_W-1:0]  tok_len;
		logic [CNT_W-1:0]  err_line;
		logic [CNT_W-1:0]  err_col;
	} bundle_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_ONE;
	endfunction

	function automatic nfa_set_t start_set();
		nfa_set_t s;
		s = '0;
		for (int k = 0; k < NUM_KINDS; k++) begin
			s[KIND_START[k]-1] = 1'b1;
		end
		return s;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {["a":"z"], ["A":"Z"]};
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c inside {[8'h21:8'h27], [8'h2A:8'h2F], 8'h3A, [8'h3C:8'h40],
			8'h5C, 8'h5E, 8'h60, [8'h7B:8'h7E]};
	endfunction

	function automatic nfa_set_t nfa_advance(input nfa_set_t set, input logic [7:0] c);
		nfa_set_t nx;
		nx = '0;
		for (int s = 0; s < CHAIN_LAST; s++) begin
			if (CHAIN_CHAR[s] != 8'h00 && set[s] && c == CHAIN_CHAR[s]) begin
				nx[s+1] = 1'b1;
			end
		end
		if ((set[ST_NUM_START-1] || set[ST_NUM_ACCEPT-1]) && is_digit(c)) begin
			nx[ST_NUM_ACCEPT-1] = 1'b1;
		end
		if ((set[ST_OPID_START-1] && is_op(c)) ||
			(set[ST_OPID_ACCEPT-1] && (is_op(c) || is_word(c)))) begin
			nx[ST_OPID_ACCEPT-1] = 1'b1;
		end
		if ((set[ST_ID_START-1] && (is_alpha(c) || c == CH_UNDER)) ||
			(set[ST_ID_ACCEPT-1] && is_word(c))) begin
			nx[ST_ID_ACCEPT-1] = 1'b1;
		end
		return nx;
	endfunction

	// Highest-priority accepting kind; found is low when none accepts
	function automatic logic [KIND_W:0] nfa_kind(input nfa_set_t set);
		logic [KIND_W:0] r;
		r = '0;
		for (int k = NUM_KINDS - 1; k >= 0; k--) begin
			if (set[KIND_ACCEPT[k]-1]) begin
				r = {1'b1, KIND_W'(k)};
			end
		end
		return r;
	endfunction

endpackage

@@ hdl/maximal_munch_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// maximal_munch_tokenizer_core
// Longest-match tokenizer: one byte in per cycle while the queue has room, token and error results out.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue is not full; the NFA step in the front sets that figure.
// A result passes through the queue and then the output register after the byte that ends its token.
// A token followed by an error leaves one bundle as two results, the token first.
// Reset: arst_n clears counters, NFA set, queue and output asynchronously.
module maximal_munch_tokenizer_core #(
	parameter int QUEUE_DEPTH = mmt_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  mmt_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output mmt_pkg::result_t result
);

	logic             q_push, q_full, q_pop, q_empty;
	mmt_pkg::bundle_t q_in, q_head;

	mmt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	mmt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	mmt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ hdl/mmt_front.sv @@
// ----------------------------------------------------------------------------
// mmt_front
// Accepts bytes, steps the NFA bit set and counters, and queues the results
// that each byte causes as one bundle.
// ----------------------------------------------------------------------------
module mmt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  mmt_pkg::item_t  item,
	input  logic            q_full,
	output logic            q_push,
	output mmt_pkg::bundle_t q_data
);

	mmt_pkg::nfa_set_t                active_q, active_d;
	logic [mmt_pkg::KIND_W-1:0]       kind_q, kind_d;
	logic                             pend_q, pend_d;
	logic [mmt_pkg::CNT_W-1:0]        tline_q, tline_d;
	logic [mmt_pkg::CNT_W-1:0]        tcol_q, tcol_d;
	logic [mmt_pkg::CNT_W-1:0]        tlen_q, tlen_d;
	logic [mmt_pkg::CNT_W-1:0]        line_q, line_d;
	logic [mmt_pkg::CNT_W-1:0]        col_q, col_d;
	logic                             halt_q, halt_d;

	mmt_pkg::nfa_set_t                adv, adv0;
	logic [mmt_pkg::KIND_W:0]         kadv, kadv0;
	logic                             take;
	logic [7:0]                       c;

	assign item_ready = !q_full;
	assign take       = item_valid && item_ready;
	assign c          = item.byte_value;
	assign adv        = mmt_pkg::nfa_advance(active_q, c);
	assign adv0       = mmt_pkg::nfa_advance(mmt_pkg::start_set(), c);
	assign kadv       = mmt_pkg::nfa_kind(adv);
	assign kadv0      = mmt_pkg::nfa_kind(adv0);

	always_comb begin
		active_d = active_q;
		kind_d   = kind_q;
		pend_d   = pend_q;
		tline_d  = tline_q;
		tcol_d   = tcol_q;
		tlen_d   = tlen_q;
		line_d   = line_q;
		col_d    = col_q;
		halt_d   = halt_q;
		q_data   = '0;
		q_data.kind     = kind_q;
		q_data.tok_line = tline_q;
		q_data.tok_col  = tcol_q;
		q_data.tok_len  = tlen_q;
		q_data.err_line = line_q;
		q_data.err_col  = col_q;
		if (take && !halt_q) begin
			if (item.end_of_input) begin
				q_data.tok_v = pend_q;
				active_d = mmt_pkg::start_set();
				kind_d   = mmt_pkg::KIND_LET;
				pend_d   = 1'b0;
				tline_d  = mmt_pkg::CNT_ONE;
				tcol_d   = mmt_pkg::CNT_ONE;
				tlen_d   = '0;
				line_d   = mmt_pkg::CNT_ONE;
				col_d    = mmt_pkg::CNT_ONE;
			end else if (pend_q && adv != '0) begin
				active_d = adv;
				if (kadv[mmt_pkg::KIND_W]) begin
					kind_d = kadv[mmt_pkg::KIND_W-1:0];
				end
				tlen_d = mmt_pkg::sat_inc(tlen_q);
				col_d  = mmt_pkg::sat_inc(col_q);
			end else begin
				q_data.tok_v = pend_q;
				active_d = mmt_pkg::start_set();
				pend_d   = 1'b0;
				tlen_d   = '0;
				if (mmt_pkg::is_space(c)) begin
					if (c == mmt_pkg::CH_NEWLINE) begin
						line_d = mmt_pkg::sat_inc(line_q);
						col_d  = mmt_pkg::CNT_ONE;
					end else begin
						col_d = mmt_pkg::sat_inc(col_q);
					end
				end else if (adv0 == '0) begin
					q_data.err_v = 1'b1;
					halt_d       = 1'b1;
				end else begin
					active_d = adv0;
					kind_d   = kadv0[mmt_pkg::KIND_W] ? kadv0[mmt_pkg::KIND_W-1:0]
						: mmt_pkg::KIND_LET;
					pend_d   = 1'b1;
					tline_d  = line_q;
					tcol_d   = col_q;
					tlen_d   = mmt_pkg::CNT_ONE;
					col_d    = mmt_pkg::sat_inc(col_q);
				end
			end
		end
	end

	assign q_push = q_data.tok_v || q_data.err_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= mmt_pkg::start_set();
			kind_q   <= mmt_pkg::KIND_LET;
			pend_q   <= 1'b0;
			tline_q  <= mmt_pkg::CNT_ONE;
			tcol_q   <= mmt_pkg::CNT_ONE;
			tlen_q   <= '0;
			line_q   <= mmt_pkg::CNT_ONE;
			col_q    <= mmt_pkg::CNT_ONE;
			halt_q   <= 1'b0;
		end else begin
			active_q <= active_d;
			kind_q   <= kind_d;
			pend_q   <= pend_d;
			tline_q  <= tline_d;
			tcol_q   <= tcol_d;
			tlen_q   <= tlen_d;
			line_q   <= line_d;
			col_q    <= col_d;
			halt_q   <= halt_d;
		end
	end

endmodule

@@ hdl/mmt_queue.sv @@
// ----------------------------------------------------------------------------
// mmt_queue
// Short register queue of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
module mmt_queue #(
	parameter int DEPTH = mmt_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mmt_pkg::bundle_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output mmt_pkg::bundle_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mmt_pkg::bundle_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wrap_inc(wr_q);
			end
			if (do_pop) begin
				rd_q <= wrap_inc(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ hdl/mmt_back.sv @@
// ----------------------------------------------------------------------------
// mmt_back
// Splits each queued bundle into its token and error results and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module mmt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  mmt_pkg::bundle_t  q_head,
	output logic              q_pop,
	output logic              result_valid,
	input  logic              result_ready,
	output mmt_pkg::result_t  result
);

	logic             valid_q;
	mmt_pkg::result_t res_q, res_d;
	logic             phase_q, phase_d;
	logic             load;

	assign load = !q_empty && (!valid_q || result_ready);

	always_comb begin
		res_d   = '0;
		phase_d = phase_q;
		q_pop   = 1'b0;
		if (q_head.tok_v && !phase_q) begin
			res_d.token_kind   = q_head.kind;
			res_d.start_line   = q_head.tok_line;
			res_d.start_column = q_head.tok_col;
			res_d.token_length = q_head.tok_len;
			res_d.last_of_run  = !q_head.err_v;
			if (load) begin
				phase_d = q_head.err_v;
				q_pop   = !q_head.err_v;
			end
		end else begin
			res_d.is_error     = 1'b1;
			res_d.token_kind   = mmt_pkg::KIND_LET;
			res_d.start_line   = q_head.err_line;
			res_d.start_column = q_head.err_col;
			res_d.last_of_run  = 1'b1;
			if (load) begin
				phase_d = 1'b0;
				q_pop   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (load) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;
	assign result       = res_q;

endmodule

@@ hdl/mmt_checker.sv @@
// ----------------------------------------------------------------------------
// mmt_checker
// Port-level checks of the tokenizer's channels, bound to the top level.
// ----------------------------------------------------------------------------
module mmt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input mmt_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_ready,
	input mmt_pkg::result_t result
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("input transaction changed while stalled");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result transaction changed while stalled");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_error |->
			result.token_kind == mmt_pkg::KIND_LET && result.token_length == '0 &&
			result.last_of_run)
		else $error("error result with token fields set");

	a_tok_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_error |-> result.token_length != '0 &&
			int'(result.token_kind) < mmt_pkg::NUM_KINDS)
		else $error("token result with zero length or bad kind");

	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.start_line != '0 && result.start_column != '0)
		else $error("result position below one");

endmodule

bind maximal_munch_tokenizer_core mmt_checker u_mmt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
